// ===== sv/bbce_pkg.sv =====
// ----------------------------------------------------------------------------
// bbce_pkg
// Shared constants, widths and controller/datapath interface types for the
// box blur frame store.
// ----------------------------------------------------------------------------
package bbce_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_RADIUS   = 8;
  localparam int CHANNEL_BITS = 16;

  localparam int NUM_CHAN  = 3;
  localparam int X_W       = $clog2(MAX_WIDTH);
  localparam int Y_W       = $clog2(MAX_HEIGHT);
  localparam int ADDR_W    = X_W + Y_W;
  localparam int DEPTH     = 1 << ADDR_W;
  localparam int PIX_W     = NUM_CHAN * CHANNEL_BITS;
  localparam int COORD_W   = ((X_W > Y_W) ? X_W : Y_W) + 2;
  localparam int R_W       = $clog2(MAX_RADIUS + 1);
  localparam int OFF_W     = $clog2(2 * MAX_RADIUS);
  localparam int SUM_W     = CHANNEL_BITS + $clog2(4 * MAX_RADIUS * MAX_RADIUS + 1);
  localparam int DVS_W     = $clog2(MAX_RADIUS * MAX_RADIUS + 1);
  localparam int DCNT_W    = $clog2(SUM_W);

  // Fixed widths of the register file and the item fields
  localparam int SIZE_W    = 9;
  localparam int RREG_W    = 4;
  localparam int COORD_IN_W = 8;
  localparam int CHAN_IN_W = 16;
  localparam int OUT_W     = 16;
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  // Register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic [SIZE_W-1:0] RST_WIDTH  = SIZE_W'(256);
  localparam logic [SIZE_W-1:0] RST_HEIGHT = SIZE_W'(256);
  localparam logic [RREG_W-1:0] RST_RADIUS = RREG_W'(1);

  typedef struct packed {
    logic [SIZE_W-1:0] width;
    logic [SIZE_W-1:0] height;
    logic [RREG_W-1:0] radius;
  } cfg_t;

  typedef struct packed {
    logic write;
    logic load;
    logic walk;
    logic div_init;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic walk_last;
    logic div_last;
    logic out_free;
  } status_t;

endpackage

// ===== sv/box_blur_clamped_edges.sv =====
// Write item: written to the frame store in the cycle it is accepted; the next item may follow at once.
// Read item: a window walk of one frame store read per cycle (r = 0 walks one pixel),
//   then a drain, the divide setup and a bit-serial divide before the result is loaded.
//   One read is at work at a time, so no item is taken until the result has been
//   loaded into the output register, where it waits.
// Reset clears control state and loads the registers; the frame store is not cleared.
// ----------------------------------------------------------------------------
// box_blur_clamped_edges
// Frame store with a box blur engine over an edge-clamped 2r by 2r window,
// configured through a small APB-style register port.
// ----------------------------------------------------------------------------
module box_blur_clamped_edges
  import bbce_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_AW-1:0]     paddr,
  input  logic [APB_DW-1:0]     pwdata,
  output logic [APB_DW-1:0]     prdata,
  output logic                  pready,
  // Item input
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  func_i,
  input  logic [COORD_IN_W-1:0] pixel_x_i,
  input  logic [COORD_IN_W-1:0] pixel_y_i,
  input  logic [CHAN_IN_W-1:0]  in_red_i,
  input  logic [CHAN_IN_W-1:0]  in_green_i,
  input  logic [CHAN_IN_W-1:0]  in_blue_i,
  // Result output
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [OUT_W-1:0]      out_red_o,
  output logic [OUT_W-1:0]      out_green_o,
  output logic [OUT_W-1:0]      out_blue_o
);

  // --------------------------------------------------------------------------
  // Register file: width, height, radius at byte addresses 0, 4, 8.
  // Raw values are kept; the datapath derives the effective limits.
  // --------------------------------------------------------------------------
  cfg_t       cfg_q;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= RST_WIDTH;
      cfg_q.height <= RST_HEIGHT;
      cfg_q.radius <= RST_RADIUS;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_WIDTH:  cfg_q.width  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: cfg_q.height <= pwdata[SIZE_W-1:0];
        REG_RADIUS: cfg_q.radius <= pwdata[RREG_W-1:0];
        default: begin
          // unmapped address: drop the write
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_WIDTH:  prdata = APB_DW'(cfg_q.width);
      REG_HEIGHT: prdata = APB_DW'(cfg_q.height);
      REG_RADIUS: prdata = APB_DW'(cfg_q.radius);
      default:    prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Controller and datapath. The controller accepts an item only in idle;
  // a write goes straight into the frame store, a read starts the walk.
  // --------------------------------------------------------------------------
  cmd_t    cmd;
  status_t status;

  bbce_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .func_i     (func_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bbce_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_i       (cfg_q),
    .pixel_x_i   (pixel_x_i),
    .pixel_y_i   (pixel_y_i),
    .in_red_i    (in_red_i),
    .in_green_i  (in_green_i),
    .in_blue_i   (in_blue_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_red_o   (out_red_o),
    .out_green_o (out_green_o),
    .out_blue_o  (out_blue_o)
  );

endmodule

// ===== sv/bbce_ram.sv =====
// ----------------------------------------------------------------------------
// bbce_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module bbce_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/bbce_ctrl.sv =====
// ----------------------------------------------------------------------------
// bbce_ctrl
// Sequencer: window walk, drain, divide setup, divide steps, result hand-off.
// ----------------------------------------------------------------------------
module bbce_ctrl
  import bbce_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    func_i,
  output logic    in_stall_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_WALK  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_PREP  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (func_i) begin
            cmd_o.load = 1'b1;
            state_d    = S_WALK;
          end else begin
            cmd_o.write = 1'b1;
          end
        end
      end
      S_WALK: begin
        cmd_o.walk = 1'b1;
        if (status_i.walk_last) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_d = S_PREP;
      end
      S_PREP: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (status_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== sv/bbce_dp.sv =====
// ----------------------------------------------------------------------------
// bbce_dp
// Datapath: window address generation, frame store, channel accumulators,
// restoring dividers and output register.
// ----------------------------------------------------------------------------
module bbce_dp
  import bbce_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  cfg_t                  cfg_i,
  input  logic [COORD_IN_W-1:0] pixel_x_i,
  input  logic [COORD_IN_W-1:0] pixel_y_i,
  input  logic [CHAN_IN_W-1:0]  in_red_i,
  input  logic [CHAN_IN_W-1:0]  in_green_i,
  input  logic [CHAN_IN_W-1:0]  in_blue_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic [OUT_W-1:0]      out_red_o,
  output logic [OUT_W-1:0]      out_green_o,
  output logic [OUT_W-1:0]      out_blue_o
);

  // Effective image limits (last valid column and row) and radius
  logic [SIZE_W-1:0] wlast, hlast;
  logic [R_W-1:0]    r_eff;
  logic [X_W-1:0]    cx;
  logic [Y_W-1:0]    cy;

  always_comb begin
    if (cfg_i.width == '0) begin
      wlast = '0;
    end else if (cfg_i.width > SIZE_W'(MAX_WIDTH)) begin
      wlast = SIZE_W'(MAX_WIDTH - 1);
    end else begin
      wlast = cfg_i.width - SIZE_W'(1);
    end
    if (cfg_i.height == '0) begin
      hlast = '0;
    end else if (cfg_i.height > SIZE_W'(MAX_HEIGHT)) begin
      hlast = SIZE_W'(MAX_HEIGHT - 1);
    end else begin
      hlast = cfg_i.height - SIZE_W'(1);
    end
    if (cfg_i.radius > RREG_W'(MAX_RADIUS)) begin
      r_eff = R_W'(MAX_RADIUS);
    end else begin
      r_eff = R_W'(cfg_i.radius);
    end
    cx = (SIZE_W'(pixel_x_i) > wlast) ? wlast[X_W-1:0] : X_W'(pixel_x_i);
    cy = (SIZE_W'(pixel_y_i) > hlast) ? hlast[Y_W-1:0] : Y_W'(pixel_y_i);
  end

  // Per-read context
  logic [X_W-1:0]   cx_q, wmax_q;
  logic [Y_W-1:0]   cy_q, hmax_q;
  logic [R_W-1:0]   r_q;
  logic             r0_q;
  logic [DVS_W-1:0] dvs_q;
  logic [OFF_W-1:0] ox_q, oy_q, olast_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q    <= cx;
      cy_q    <= cy;
      wmax_q  <= wlast[X_W-1:0];
      hmax_q  <= hlast[Y_W-1:0];
      r_q     <= r_eff;
      r0_q    <= (r_eff == '0);
      dvs_q   <= (r_eff == '0) ? DVS_W'(1) : DVS_W'(r_eff * r_eff);
      olast_q <= OFF_W'({r_eff, 1'b0} - (R_W + 1)'(1));
    end
  end

  // Window counters: columns inner, rows outer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ox_q <= '0;
      oy_q <= '0;
    end else if (cmd_i.walk) begin
      if (ox_q == olast_q) begin
        ox_q <= '0;
        oy_q <= oy_q + OFF_W'(1);
      end else begin
        ox_q <= ox_q + OFF_W'(1);
      end
    end
  end

  assign status_o.walk_last = r0_q || ((ox_q == olast_q) && (oy_q == olast_q));

  // Clamped window coordinates
  logic signed [COORD_W-1:0] wx, wy;
  logic [X_W-1:0]            bx;
  logic [Y_W-1:0]            by;

  always_comb begin
    wx = $signed(COORD_W'(cx_q)) - $signed(COORD_W'(r_q)) + $signed(COORD_W'(ox_q));
    wy = $signed(COORD_W'(cy_q)) - $signed(COORD_W'(r_q)) + $signed(COORD_W'(oy_q));
    if (wx < 0) begin
      bx = '0;
    end else if (wx > $signed(COORD_W'(wmax_q))) begin
      bx = wmax_q;
    end else begin
      bx = wx[X_W-1:0];
    end
    if (wy < 0) begin
      by = '0;
    end else if (wy > $signed(COORD_W'(hmax_q))) begin
      by = hmax_q;
    end else begin
      by = wy[Y_W-1:0];
    end
  end

  // Frame store
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  ram_wdata, ram_rdata;
  logic              wr_en;

  assign wr_en = cmd_i.write && (SIZE_W'(pixel_x_i) < SIZE_W'(MAX_WIDTH))
                             && (SIZE_W'(pixel_y_i) < SIZE_W'(MAX_HEIGHT));
  assign ram_addr = cmd_i.write ? {Y_W'(pixel_y_i), X_W'(pixel_x_i)} : {by, bx};
  assign ram_wdata = {in_blue_i[CHANNEL_BITS-1:0], in_green_i[CHANNEL_BITS-1:0],
                      in_red_i[CHANNEL_BITS-1:0]};

  bbce_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_pixel_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .re_i    (cmd_i.walk),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Accumulate read data in the cycle after each issued read
  logic rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q <= 1'b0;
    end else begin
      rd_valid_q <= cmd_i.walk;
    end
  end

  logic [SUM_W-1:0]  acc_q [NUM_CHAN];
  logic [SUM_W-1:0]  quo_q [NUM_CHAN];
  logic [DVS_W-1:0]  rem_q [NUM_CHAN];
  logic [DCNT_W-1:0] dcnt_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (cmd_i.load) begin
        acc_q[c] <= '0;
      end else if (rd_valid_q) begin
        acc_q[c] <= acc_q[c] + SUM_W'(ram_rdata[c*CHANNEL_BITS +: CHANNEL_BITS]);
      end
    end
  end

  // Restoring divide, one quotient bit per cycle on every channel
  logic [DVS_W:0]   rs   [NUM_CHAN];
  logic             ge   [NUM_CHAN];
  logic [DVS_W-1:0] rnew [NUM_CHAN];

  always_comb begin
    for (int c = 0; c < NUM_CHAN; c++) begin
      rs[c]   = {rem_q[c], quo_q[c][SUM_W-1]};
      ge[c]   = (rs[c] >= {1'b0, dvs_q});
      rnew[c] = ge[c] ? DVS_W'(rs[c] - {1'b0, dvs_q}) : rs[c][DVS_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (cmd_i.div_init) begin
        // Divide by 4r^2 as (sum >> 2) / r^2; radius zero passes the pixel
        quo_q[c] <= r0_q ? acc_q[c] : (acc_q[c] >> 2);
        rem_q[c] <= '0;
      end else if (cmd_i.div_step) begin
        quo_q[c] <= {quo_q[c][SUM_W-2:0], ge[c]};
        rem_q[c] <= rnew[c];
      end
    end
  end

  assign status_o.div_last = (dcnt_q == DCNT_W'(SUM_W - 1));

  // Output register
  logic             out_valid_q;
  logic [OUT_W-1:0] out_q [NUM_CHAN];

  assign status_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      for (int c = 0; c < NUM_CHAN; c++) begin
        out_q[c] <= quo_q[c][OUT_W-1:0];
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_red_o   = out_q[0];
  assign out_green_o = out_q[1];
  assign out_blue_o  = out_q[2];

endmodule
